### hw/rtl/three_frame_difference_motion_mask_defines.svh
// Assertion macros for the three-frame difference motion mask.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef THREE_FRAME_DIFFERENCE_MOTION_MASK_DEFINES_SVH
`define THREE_FRAME_DIFFERENCE_MOTION_MASK_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TFDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TFDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tfdm_pkg.sv
// Shared constants and types of the three-frame difference motion mask.
// No dependencies.
package tfdm_pkg;

  localparam int unsigned MAX_PIXELS = 524288;
  localparam int unsigned ADDR_W     = $clog2(MAX_PIXELS);
  localparam int unsigned SIZE_W     = ADDR_W + 1;
  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned FP_W       = 20;
  localparam int unsigned CMP_W      = (SIZE_W > FP_W) ? SIZE_W : FP_W;
  localparam int unsigned CFG_W      = 20;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 1'd1;

  localparam logic [THR_W-1:0] THRESHOLD_RST    = 8'd25;
  localparam logic [FP_W-1:0]  FRAME_PIXELS_RST = 20'd307200;

  // Frames fully stored, saturating at two.
  localparam logic [1:0] FRAMES_ONE = 2'd1;
  localparam logic [1:0] FRAMES_TWO = 2'd2;

  typedef struct packed {
    logic motion;
    logic frame_end;
  } tfdm_result_t;

  typedef struct packed {
    logic         valid;
    tfdm_result_t res;
  } tfdm_push_t;

endpackage

### hw/rtl/tfdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfdm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/tfdm_front.sv
// Front end: config registers, raster position, frame store access and compare.
// Depends on tfdm_pkg and tfdm_ram.
module tfdm_front import tfdm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [GRAY_W-1:0]    gray_pixel_i,
  input  logic [QCNT_W-1:0]    q_count_i,
  output tfdm_push_t           push_o,
  output logic                 busy_o
);

  localparam int unsigned SUM_W = QCNT_W + 1;

  logic [THR_W-1:0]  thr_q;
  logic [FP_W-1:0]   fp_q;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [1:0]        frames_q, frames_d;

  logic [CMP_W-1:0]  fp_ext, size_c;
  logic [CMP_W-1:0]  pos_ext, pos_clamp, pos_inc;
  logic [ADDR_W-1:0] pos_c;
  logic              last_c;
  logic              accept;

  // stage 1: store read data arrives here
  logic                s1_valid_q;
  logic [ADDR_W-1:0]   s1_pos_q;
  logic [GRAY_W-1:0]   s1_cur_q;
  logic                s1_last_q;
  logic                s1_emit_q;
  logic                s1_wrold_q;
  logic                byp_q;
  logic [2*GRAY_W-1:0] byp_data_q;

  logic [2*GRAY_W-1:0] rd_data, stored, wr_data;
  logic [GRAY_W-1:0]   older, newer, d1, d2;

  // credit check: items in stage 1 plus queued items must leave a free slot
  assign in_stall_o = ({1'b0, q_count_i} + SUM_W'(s1_valid_q)) >= SUM_W'(QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;
  assign busy_o     = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      fp_q  <= FRAME_PIXELS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD:    thr_q <= cfg_wdata_i[THR_W-1:0];
        REG_FRAME_PIXELS: fp_q  <= cfg_wdata_i[FP_W-1:0];
        default:          ;
      endcase
    end
  end

  // clamp frame size to 1..MAX_PIXELS
  always_comb begin
    fp_ext = CMP_W'(fp_q);
    if (fp_ext == '0) begin
      size_c = CMP_W'(1);
    end else if (fp_ext > CMP_W'(MAX_PIXELS)) begin
      size_c = CMP_W'(MAX_PIXELS);
    end else begin
      size_c = fp_ext;
    end
  end

  always_comb begin
    pos_ext   = CMP_W'(pos_q);
    pos_clamp = (pos_ext >= size_c) ? (size_c - CMP_W'(1)) : pos_ext;
    pos_c     = pos_clamp[ADDR_W-1:0];
    pos_inc   = pos_clamp + CMP_W'(1);
    last_c    = pos_inc >= size_c;
    pos_d     = last_c ? '0 : pos_inc[ADDR_W-1:0];
    frames_d  = (last_c && frames_q != FRAMES_TWO) ? frames_q + 2'd1 : frames_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      frames_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        pos_q    <= pos_d;
        frames_q <= frames_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q   <= pos_c;
      s1_cur_q   <= gray_pixel_i;
      s1_last_q  <= last_c;
      s1_emit_q  <= frames_q == FRAMES_TWO;
      s1_wrold_q <= frames_q >= FRAMES_ONE;
      // forward the write landing at this edge when it hits the same pixel
      byp_q      <= s1_valid_q && (s1_pos_q == pos_c);
      byp_data_q <= wr_data;
    end
  end

  // entry layout: older in the upper byte, newer in the lower byte
  tfdm_ram #(
    .DEPTH (MAX_PIXELS),
    .WIDTH (2 * GRAY_W)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (pos_c),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_pos_q),
    .wr_data_i (wr_data)
  );

  always_comb begin
    stored  = byp_q ? byp_data_q : rd_data;
    older   = stored[2*GRAY_W-1:GRAY_W];
    newer   = stored[GRAY_W-1:0];
    d1      = (newer >= older) ? newer - older : older - newer;
    d2      = (s1_cur_q >= newer) ? s1_cur_q - newer : newer - s1_cur_q;
    wr_data = {(s1_wrold_q ? newer : older), s1_cur_q};
    push_o.valid         = s1_valid_q && s1_emit_q;
    push_o.res.motion    = (d1 >= thr_q) && (d2 >= thr_q);
    push_o.res.frame_end = s1_last_q;
  end

endmodule

### hw/rtl/tfdm_queue.sv
// Back end: short result queue that drives the output channel.
// Depends on tfdm_pkg.
module tfdm_queue import tfdm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tfdm_push_t        push_i,
  output logic [QCNT_W-1:0] count_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tfdm_result_t      head_o
);

  tfdm_result_t      entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              pop;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = entry_q[rd_ptr_q];
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_ptr_q] <= push_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i.valid, pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### hw/rtl/three_frame_difference_motion_mask.sv
// A pixel accepted by the front end is registered in stage 1 with its frame store read;
// its result is then written into the result queue, which drives the outputs. Throughput:
// one pixel per cycle from the single frame store (read and write ports overlap) unless
// stalled; input stalls when queued results plus a pixel in stage 1 reach four (QDEPTH).
// Reset: clears position, frame count, queue and config (threshold 25, 307200 pixels);
// frame store contents stay undefined until written. Uses tfdm_front, tfdm_queue.
`include "three_frame_difference_motion_mask_defines.svh"

module three_frame_difference_motion_mask import tfdm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [GRAY_W-1:0]    gray_pixel_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 motion_o,
  output logic                 frame_end_o
);

  tfdm_push_t        push;
  tfdm_result_t      head;
  logic [QCNT_W-1:0] q_count;
  logic              busy;

  tfdm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .gray_pixel_i (gray_pixel_i),
    .q_count_i    (q_count),
    .push_o       (push),
    .busy_o       (busy)
  );

  tfdm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .count_o     (q_count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign motion_o    = head.motion;
  assign frame_end_o = head.frame_end;

  `TFDM_ASSERT(a_no_overflow, !(push.valid && q_count == QCNT_W'(QDEPTH)), "result queue overflow")
  `TFDM_ASSERT_NEXT(a_accept_in_flight, in_valid_i && !in_stall_o, busy, "accepted pixel lost")
  `TFDM_ASSERT(a_push_needs_flight, !push.valid || busy, "result pushed without a pixel in flight")

endmodule
